@@ rtl/core/sat_pkg.sv @@
// Shared types and codes of the strongest access point table.
package sat_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_OFFER = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [2:0] {
    ACT_INSERTED    = 3'd0,
    ACT_REPLACED    = 3'd1,
    ACT_DUPLICATE   = 3'd2,
    ACT_REJECTED    = 3'd3,
    ACT_CLEARED     = 3'd4,
    ACT_READ_OK     = 3'd5,
    ACT_READ_BEYOND = 3'd6
  } sat_action_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [47:0]        mac_address;
    logic signed [7:0]  signal_level;
    logic [3:0]         read_index;
  } sat_req_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         slot;
    logic [4:0]         stored_count;
    logic [47:0]        entry_mac;
    logic signed [7:0]  entry_level;
  } sat_rsp_t;

endpackage

@@ rtl/core/sat_table_mem.sv @@
// Entry memory holding the MAC and signal level of each table slot.
module sat_table_mem #(
  parameter int TABLE_DEPTH = 16,
  parameter int AW          = 4
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [47:0]   rd_mac_o,
  output logic [7:0]    rd_level_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [47:0]   wr_mac_i,
  input  logic [7:0]    wr_level_i
);

  logic [47:0] mac_mem   [TABLE_DEPTH];
  logic [7:0]  level_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mac_mem[wr_addr_i]   <= wr_mac_i;
      level_mem[wr_addr_i] <= wr_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_mac_o   <= mac_mem[rd_addr_i];
      rd_level_o <= level_mem[rd_addr_i];
    end
  end

endmodule

@@ rtl/core/sat_ctrl.sv @@
// Command sequencer that scans, updates and reads the entry memory.
module sat_ctrl
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sat_req_t      req_i,
  output logic          busy_o,
  output logic          done_o,
  output sat_rsp_t      rsp_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [47:0]   rd_mac_i,
  input  logic [7:0]    rd_level_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [47:0]   wr_mac_o,
  output logic [7:0]    wr_level_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_READ
  } state_e;

  state_e          state_q, state_d;
  sat_req_t        req_q, req_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic [CW-1:0]   chk_q, chk_d;
  logic [AW-1:0]   weak_q, weak_d;
  logic [7:0]      min_q, min_d;
  logic            done_q, done_d;
  sat_rsp_t        rsp_q, rsp_d;
  logic            accept;
  logic [7:0]      ridx_w;
  logic [7:0]      count_w;
  logic [7:0]      count_d_w;

  function automatic logic [3:0] to_slot(input logic [7:0] v);
    return v[3:0];
  endfunction

  assign accept  = start_i && (state_q == ST_IDLE);
  assign ridx_w  = {4'b0000, req_i.read_index};
  assign count_w = 8'(count_q);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    count_d    = count_q;
    iss_d      = iss_q;
    chk_d      = chk_q;
    weak_d     = weak_q;
    min_d      = min_q;
    done_d     = 1'b0;
    rsp_d      = '0;
    rd_en_o    = 1'b0;
    rd_addr_o  = iss_q[AW-1:0];
    wr_en_o    = 1'b0;
    wr_addr_o  = weak_q;
    wr_mac_o   = req_q.mac_address;
    wr_level_o = req_q.signal_level;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          case (req_i.cmd)
            CMD_CLEAR: begin
              count_d      = '0;
              rsp_d.action = ACT_CLEARED;
              done_d       = 1'b1;
            end
            CMD_OFFER: begin
              if (count_q == '0) begin
                wr_en_o      = 1'b1;
                wr_addr_o    = '0;
                wr_mac_o     = req_i.mac_address;
                wr_level_o   = req_i.signal_level;
                count_d      = CW'(1);
                rsp_d.action = ACT_INSERTED;
                done_d       = 1'b1;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = '0;
                iss_d     = CW'(1);
                chk_d     = '0;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              if (ridx_w < count_w) begin
                rd_en_o   = 1'b1;
                rd_addr_o = ridx_w[AW-1:0];
                state_d   = ST_READ;
              end else begin
                rsp_d.action = ACT_READ_BEYOND;
                done_d       = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_q < count_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = iss_q[AW-1:0];
          iss_d     = iss_q + CW'(1);
        end
        if (rd_mac_i == req_q.mac_address) begin
          rsp_d.action = ACT_DUPLICATE;
          rsp_d.slot   = to_slot(8'(chk_q));
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          if ((chk_q == '0) || ($signed(rd_level_i) < $signed(min_q))) begin
            min_d  = rd_level_i;
            weak_d = chk_q[AW-1:0];
          end
          chk_d = chk_q + CW'(1);
          if ((chk_q + CW'(1)) == count_q) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (count_q < CW'(TABLE_DEPTH)) begin
          wr_en_o      = 1'b1;
          wr_addr_o    = count_q[AW-1:0];
          count_d      = count_q + CW'(1);
          rsp_d.action = ACT_INSERTED;
          rsp_d.slot   = to_slot(count_w);
        end else if ($signed(req_q.signal_level) > $signed(min_q)) begin
          wr_en_o      = 1'b1;
          wr_addr_o    = weak_q;
          rsp_d.action = ACT_REPLACED;
          rsp_d.slot   = to_slot(8'(weak_q));
        end else begin
          rsp_d.action = ACT_REJECTED;
        end
      end
      ST_READ: begin
        rsp_d.action      = ACT_READ_OK;
        rsp_d.slot        = req_q.read_index;
        rsp_d.entry_mac   = rd_mac_i;
        rsp_d.entry_level = rd_level_i;
        done_d            = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    count_d_w          = 8'(count_d);
    rsp_d.stored_count = count_d_w[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      req_q   <= '0;
      iss_q   <= '0;
      chk_q   <= '0;
      weak_q  <= '0;
      min_q   <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      req_q   <= req_d;
      iss_q   <= iss_d;
      chk_q   <= chk_d;
      weak_q  <= weak_d;
      min_q   <= min_d;
      rsp_q   <= rsp_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_clear_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.cmd == CMD_CLEAR)) |=> (done_q && (rsp_q.stored_count == 5'd0)))
    else $error("A clear transfer did not answer with an empty table.");

  a_scan_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0))
    else $error("Scan running over an empty table.");

  a_write_idle_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !rd_en_o)
    else $error("Memory written and read in the same cycle.");

endmodule

@@ rtl/core/strongest_ap_table_top.sv @@
// Top level of the strongest access point table.
// A command transfer is taken when start_i is high and busy_o is low, and
// every command gives exactly one result on rsp_o, marked by done_o for a
// single cycle; the receiver cannot stall, so it must take each result in
// the cycle it appears. Clear, an offer into an empty table and a read
// beyond the stored count answer in the cycle after the transfer, and a
// valid read answers from the ST_READ state after its memory read. Any other
// offer scans the stored entries through the memory read port at one entry
// per cycle: a duplicate answers when it is found, and otherwise the offer
// answers from ST_DECIDE. No new command is taken while busy_o is high.
module strongest_ap_table_top
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sat_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output sat_rsp_t rsp_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [47:0]   rd_mac;
  logic [7:0]    rd_level;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [47:0]   wr_mac;
  logic [7:0]    wr_level;

  sat_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_i     (req_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_mac_i  (rd_mac),
    .rd_level_i(rd_level),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_mac_o  (wr_mac),
    .wr_level_o(wr_level)
  );

  sat_table_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_mac_o  (rd_mac),
    .rd_level_o(rd_level),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_mac_i  (wr_mac),
    .wr_level_i(wr_level)
  );

endmodule

@@ dv/tb_strongest_ap_table_top.sv @@
// Self-checking testbench of the strongest access point table top level.
`timescale 1ns / 100ps

module tb_strongest_ap_table_top;
  import sat_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  sat_req_t req_i;
  logic     busy_o;
  logic     done_o;
  sat_rsp_t rsp_o;

  logic [47:0]       tbl_mac [TABLE_DEPTH];
  logic signed [7:0] tbl_level [TABLE_DEPTH];
  int                tbl_count;

  sat_rsp_t    predicted_answers[$];
  logic [47:0] seen_macs[$];
  int unsigned items_sent;
  int unsigned failures;
  int unsigned cycle_count;
  bit          gaps_on;

  strongest_ap_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic signed [7:0] rand_level();
    case ($urandom_range(0, 9))
      0: return -8'sd128;
      1: return 8'sd127;
      2, 3: return 8'($urandom_range(0, 8) + 192);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic sat_rsp_t apply_table_cmd(sat_req_t r);
    sat_rsp_t a;
    int       found;
    int       weakest;
    a = '0;
    found = -1;
    case (r.cmd)
      CMD_CLEAR: begin
        tbl_count = 0;
        a.action = ACT_CLEARED;
      end
      CMD_OFFER: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (found < 0 && tbl_mac[i] == r.mac_address) found = i;
        end
        if (found >= 0) begin
          a.action = ACT_DUPLICATE;
          a.slot = 4'(found);
        end else if (tbl_count < TABLE_DEPTH) begin
          tbl_mac[tbl_count] = r.mac_address;
          tbl_level[tbl_count] = $signed(r.signal_level);
          a.action = ACT_INSERTED;
          a.slot = 4'(tbl_count);
          tbl_count++;
        end else begin
          weakest = 0;
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (tbl_level[i] < tbl_level[weakest]) weakest = i;
          end
          if ($signed(r.signal_level) > tbl_level[weakest]) begin
            tbl_mac[weakest] = r.mac_address;
            tbl_level[weakest] = $signed(r.signal_level);
            a.action = ACT_REPLACED;
            a.slot = 4'(weakest);
          end else begin
            a.action = ACT_REJECTED;
          end
        end
      end
      default: begin
        if (int'(r.read_index) < tbl_count) begin
          a.action = ACT_READ_OK;
          a.slot = r.read_index;
          a.entry_mac = tbl_mac[r.read_index];
          a.entry_level = tbl_level[r.read_index];
        end else begin
          a.action = ACT_READ_BEYOND;
        end
      end
    endcase
    a.stored_count = 5'(tbl_count);
    return a;
  endfunction

  task automatic send_cmd(input sat_req_t r);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_i <= r;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted_answers.push_back(apply_table_cmd(r));
    items_sent++;
  endtask

  task automatic clear_table();
    send_cmd('{cmd: CMD_CLEAR, mac_address: rand_mac(), signal_level: rand_level(),
               read_index: 4'($urandom)});
  endtask

  task automatic offer_ap(input logic [47:0] mac, input logic signed [7:0] level);
    send_cmd('{cmd: CMD_OFFER, mac_address: mac, signal_level: level,
               read_index: 4'($urandom)});
  endtask

  task automatic read_slot(input logic [1:0] cmd, input logic [3:0] idx);
    send_cmd('{cmd: cmd, mac_address: rand_mac(), signal_level: rand_level(),
               read_index: idx});
  endtask

  task automatic test_empty_table();
    read_slot(CMD_UNUSED, 4'd15);
    clear_table();
  endtask

  task automatic test_fill_table();
    logic signed [7:0] lv [TABLE_DEPTH] = '{127, -1, -90, -128, 5, -20, 64, -60,
                                            30, -128, -127, 100, -2, -50, 12, 0};
    offer_ap('0, lv[0]);
    offer_ap('1, lv[1]);
    for (int i = 2; i < TABLE_DEPTH; i++) offer_ap({16'hA5C3, 32'(i)}, lv[i]);
  endtask

  task automatic test_duplicate_offer();
    offer_ap('1, 8'sd127);
    offer_ap({16'hA5C3, 32'd15}, -8'sd128);
  endtask

  task automatic test_full_table_replacement();
    offer_ap(48'h0123_4567_89AB, -8'sd128);
    offer_ap(48'hFEDC_BA98_7654, -8'sd127);
  endtask

  task automatic test_read_back();
    read_slot(CMD_READ, 4'd1);
    read_slot(CMD_READ, 4'd3);
    read_slot(CMD_UNUSED, 4'd15);
  endtask

  task automatic run_random_scans(input int unsigned count, input bit allow_gaps);
    int unsigned target;
    int unsigned scan_len;
    int unsigned pick;
    logic [47:0] mac;
    target = items_sent + count;
    while (items_sent < target) begin
      gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) clear_table();
      scan_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 24);
      for (int unsigned n = 0; n < scan_len && items_sent < target; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          pick = $urandom_range(0, 99);
          if (pick < 25 && seen_macs.size() > 0) begin
            mac = seen_macs[$urandom_range(0, seen_macs.size() - 1)];
          end else if (pick < 30) begin
            mac = $urandom_range(0, 1) ? '1 : '0;
          end else begin
            mac = rand_mac();
            seen_macs.push_back(mac);
            if (seen_macs.size() > 48) void'(seen_macs.pop_front());
          end
          offer_ap(mac, rand_level());
        end else if (pick < 95) begin
          read_slot((pick < 88) ? CMD_READ : CMD_UNUSED,
                    (tbl_count > 0 && $urandom_range(0, 3) != 0) ?
                      4'($urandom_range(0, tbl_count - 1)) : 4'($urandom_range(0, 15)));
        end else begin
          clear_table();
        end
      end
    end
  endtask

  task automatic test_random_scans();
    run_random_scans(1600, 1'b1);
  endtask

  task automatic test_quiet_tail();
    run_random_scans(200, 1'b0);
  endtask

  always @(posedge clk_i) begin
    sat_rsp_t want;
    if (rst_ni && done_o) begin
      if (predicted_answers.size() == 0) begin
        $error("unexpected result: action %0d slot %0d", rsp_o.action, rsp_o.slot);
        failures++;
      end else begin
        want = predicted_answers.pop_front();
        if (rsp_o.action !== want.action) begin
          $error("action: expected %0d, actual %0d", want.action, rsp_o.action);
          failures++;
        end
        if (rsp_o.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, rsp_o.slot);
          failures++;
        end
        if (rsp_o.stored_count !== want.stored_count) begin
          $error("stored_count: expected %0d, actual %0d", want.stored_count,
                 rsp_o.stored_count);
          failures++;
        end
        if (rsp_o.entry_mac !== want.entry_mac) begin
          $error("entry_mac: expected %h, actual %h", want.entry_mac, rsp_o.entry_mac);
          failures++;
        end
        if (rsp_o.entry_level !== want.entry_level) begin
          $error("entry_level: expected %0d, actual %0d", want.entry_level,
                 rsp_o.entry_level);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    tbl_count = 0;
    items_sent = 0;
    failures = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_table();
    test_duplicate_offer();
    test_full_table_replacement();
    test_read_back();
    test_random_scans();
    test_quiet_tail();
    start_i <= 1'b0;
    while (predicted_answers.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
